>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the LED grid parser RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LGCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LGCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/lgcp_pkg.sv
// Shared types and constants of the LED grid command parser.
// No dependencies; the core, front end, queue and back end refer to it by scoped names.
`timescale 1ns / 1ps

package lgcp_pkg;

  localparam int CELLS_PER_WORD = 8;
  localparam int LEVEL_W        = 4;
  localparam int WORD_W         = CELLS_PER_WORD * LEVEL_W;

  localparam logic [3:0] BRIGHT_RESET = 4'hF;

  // Command opcodes (top nibble of a command byte).
  localparam logic [3:0] OP_LED_ON  = 4'd2;
  localparam logic [3:0] OP_LED_OFF = 4'd3;
  localparam logic [3:0] OP_COL     = 4'd4;
  localparam logic [3:0] OP_ROW     = 4'd5;
  localparam logic [3:0] OP_COL16   = 4'd6;
  localparam logic [3:0] OP_ROW16   = 4'd7;
  localparam logic [3:0] OP_FRAME   = 4'd8;
  localparam logic [3:0] OP_CLEAR   = 4'd9;
  localparam logic [3:0] OP_BRIGHT  = 4'd10;
  localparam logic [3:0] OP_MODE    = 4'd11;
  localparam logic [3:0] OP_PORT_A  = 4'd12;
  localparam logic [3:0] OP_PORT_B  = 4'd13;

  // Mode command arguments.
  localparam logic [3:0] MODE_NOP     = 4'd0;
  localparam logic [3:0] MODE_ALL_ON  = 4'd1;
  localparam logic [3:0] MODE_ALL_OFF = 4'd2;
  localparam logic [3:0] MODE_NATIVE  = 4'd3;
  localparam logic [3:0] MODE_GRID    = 4'd4;

  // Error codes reported with a result.
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_CMD  = 2'd1;
  localparam logic [1:0] ERR_MODE = 2'd2;

  // Work the back end carries out for one request.
  typedef enum logic [2:0] {
    K_NONE = 3'd0,
    K_READ = 3'd1,
    K_CELL = 3'd2,
    K_ROWW = 3'd3,
    K_COLW = 3'd4,
    K_FILL = 3'd5
  } kind_t;

  // For K_ROWW a col of zero enables the whole word; any other value enables nothing.
  // For K_COLW row holds the first row of the walk.
  typedef struct packed {
    kind_t       kind;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [7:0]  bits;
    logic [3:0]  lvl;
    logic [1:0]  err;
    logic        done;
    logic        boot;
  } job_t;

endpackage

>>> hw/rtl/lgcp_if.sv
// Valid/ready channel interfaces for requests and results of the LED grid parser.
// Depends on nothing.
`timescale 1ns / 1ps

interface lgcp_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;
  logic [3:0] read_row;
  logic [2:0] read_col;

  modport source (output valid, req_type, rx_byte, read_row, read_col, input ready);
  modport sink (input valid, req_type, rx_byte, read_row, read_col, output ready);
endinterface

interface lgcp_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] read_level;
  logic [1:0] error_code;
  logic       message_done;
  logic       boot_mode;

  modport source (output valid, read_level, error_code, message_done, boot_mode, input ready);
  modport sink (input valid, read_level, error_code, message_done, boot_mode, output ready);
endinterface

>>> hw/rtl/led_grid_command_parser_core.sv
// LED grid command parser: request in, one result out per request.
// A read, single LED, row or frame byte touches at most one row word; a column byte walks
// eight row words, and clear or set-all walks all GRID_ROWS row words. The back end has
// one read-modify-write port on the row words and takes the next job only after the result
// of the last one has gone to the output register; the two-entry queue in front of it holds
// further requests meanwhile. Synchronous active-low reset clears
// all levels, sets brightness to 15 and boot mode to native.
`timescale 1ns / 1ps

module led_grid_command_parser_core #(
  parameter int GRID_ROWS = 10,
  parameter int GRID_COLS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  lgcp_in_if.sink     in_ch,
  lgcp_out_if.source  out_ch
);

  logic            push;
  logic            q_full;
  logic            pop;
  logic            head_valid;
  lgcp_pkg::job_t  push_job;
  lgcp_pkg::job_t  head_job;

  lgcp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .job    (push_job)
  );

  lgcp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  lgcp_back #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (head_valid),
    .job_in    (head_job),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

>>> hw/rtl/lgcp_front.sv
// Front end: accepts requests, runs the protocol parser state and emits one job each.
// Depends on lgcp_pkg, lgcp_in_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lgcp_front (
  input  logic            clk,
  input  logic            rst_n,
  lgcp_in_if.sink         in_ch,
  input  logic            q_full,
  output logic            push,
  output lgcp_pkg::job_t  job
);

  logic [3:0] pend_op_r, pend_op_nxt;
  logic [3:0] pend_arg_r, pend_arg_nxt;
  logic [3:0] bytes_left_r, bytes_left_nxt;
  logic [2:0] byte_idx_r, byte_idx_nxt;
  logic [3:0] bright_r, bright_nxt;
  logic       saved_mode_r, saved_mode_nxt;
  logic [3:0] op;
  logic [3:0] arg;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && in_ch.ready;
  assign op          = in_ch.rx_byte[7:4];
  assign arg         = in_ch.rx_byte[3:0];

  always_comb begin
    pend_op_nxt    = pend_op_r;
    pend_arg_nxt   = pend_arg_r;
    bytes_left_nxt = bytes_left_r;
    byte_idx_nxt   = byte_idx_r;
    bright_nxt     = bright_r;
    saved_mode_nxt = saved_mode_r;
    job.kind = lgcp_pkg::K_NONE;
    job.row  = '0;
    job.col  = '0;
    job.bits = '0;
    job.lvl  = bright_r;
    job.err  = lgcp_pkg::ERR_NONE;
    job.done = 1'b0;

    if (in_ch.req_type) begin
      job.kind = lgcp_pkg::K_READ;
      job.row  = in_ch.read_row;
      job.col  = {1'b0, in_ch.read_col};
    end else if (bytes_left_r == 4'd0) begin
      // Command byte.
      pend_op_nxt  = op;
      pend_arg_nxt = arg;
      byte_idx_nxt = '0;
      case (op)
        lgcp_pkg::OP_LED_ON, lgcp_pkg::OP_LED_OFF,
        lgcp_pkg::OP_COL, lgcp_pkg::OP_ROW: begin
          bytes_left_nxt = 4'd1;
        end
        lgcp_pkg::OP_COL16, lgcp_pkg::OP_ROW16: begin
          bytes_left_nxt = 4'd2;
        end
        lgcp_pkg::OP_FRAME: begin
          bytes_left_nxt = 4'd8;
        end
        lgcp_pkg::OP_CLEAR: begin
          job.kind = lgcp_pkg::K_FILL;
          job.bits = (arg != 4'd0) ? 8'hFF : 8'h00;
          job.done = 1'b1;
        end
        lgcp_pkg::OP_BRIGHT: begin
          bright_nxt = arg;
          job.done   = 1'b1;
        end
        lgcp_pkg::OP_MODE: begin
          job.done = 1'b1;
          case (arg)
            lgcp_pkg::MODE_NOP: begin
            end
            lgcp_pkg::MODE_ALL_ON: begin
              job.kind = lgcp_pkg::K_FILL;
              job.bits = 8'hFF;
            end
            lgcp_pkg::MODE_ALL_OFF: begin
              job.kind = lgcp_pkg::K_FILL;
            end
            lgcp_pkg::MODE_NATIVE: begin
              saved_mode_nxt = 1'b1;
            end
            lgcp_pkg::MODE_GRID: begin
              saved_mode_nxt = 1'b0;
            end
            default: begin
              job.err = lgcp_pkg::ERR_MODE;
            end
          endcase
        end
        lgcp_pkg::OP_PORT_A, lgcp_pkg::OP_PORT_B: begin
          job.done = 1'b1;
        end
        default: begin
          job.err  = lgcp_pkg::ERR_CMD;
          job.done = 1'b1;
        end
      endcase
      if (job.done) begin
        pend_op_nxt = '0;
      end
    end else begin
      // Argument byte of a pending command.
      bytes_left_nxt = bytes_left_r - 4'd1;
      byte_idx_nxt   = byte_idx_r + 3'd1;
      job.bits       = in_ch.rx_byte;
      case (pend_op_r)
        lgcp_pkg::OP_LED_ON, lgcp_pkg::OP_LED_OFF: begin
          job.kind = lgcp_pkg::K_CELL;
          job.row  = in_ch.rx_byte[7:4];
          job.col  = in_ch.rx_byte[3:0];
          job.bits = (pend_op_r == lgcp_pkg::OP_LED_ON) ? 8'hFF : 8'h00;
        end
        lgcp_pkg::OP_COL: begin
          job.kind = lgcp_pkg::K_COLW;
          job.col  = pend_arg_r;
        end
        lgcp_pkg::OP_ROW: begin
          job.kind = lgcp_pkg::K_ROWW;
          job.row  = pend_arg_r;
        end
        lgcp_pkg::OP_COL16: begin
          job.kind = lgcp_pkg::K_COLW;
          job.col  = pend_arg_r;
          job.row  = (byte_idx_r == 3'd0) ? 4'd0 : 4'd8;
        end
        lgcp_pkg::OP_ROW16: begin
          job.kind = lgcp_pkg::K_ROWW;
          job.row  = pend_arg_r;
          job.col  = (byte_idx_r == 3'd0) ? 4'd0 : 4'd8;
        end
        lgcp_pkg::OP_FRAME: begin
          // Quadrant row: lower half when the argument is above one.
          job.kind = lgcp_pkg::K_ROWW;
          job.row  = {(pend_arg_r > 4'd1), byte_idx_r};
          job.col  = pend_arg_r[0] ? 4'd8 : 4'd0;
        end
        default: begin
          job.kind = lgcp_pkg::K_NONE;
        end
      endcase
      if (bytes_left_nxt == 4'd0) begin
        job.done    = 1'b1;
        pend_op_nxt = '0;
      end
    end
    job.boot = saved_mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_op_r    <= '0;
      pend_arg_r   <= '0;
      bytes_left_r <= '0;
      byte_idx_r   <= '0;
      bright_r     <= lgcp_pkg::BRIGHT_RESET;
      saved_mode_r <= 1'b1;
    end else if (push) begin
      pend_op_r    <= pend_op_nxt;
      pend_arg_r   <= pend_arg_nxt;
      bytes_left_r <= bytes_left_nxt;
      byte_idx_r   <= byte_idx_nxt;
      bright_r     <= bright_nxt;
      saved_mode_r <= saved_mode_nxt;
    end
  end

  `LGCP_ASSERT_IMP(a_left_bound, 1'b1, bytes_left_r <= 4'd8, "argument count above eight")
  `LGCP_ASSERT_NXT(a_arg_count, push && !in_ch.req_type && (bytes_left_r != 4'd0), bytes_left_r == ($past(bytes_left_r) - 4'd1), "argument byte did not decrement count")

endmodule

>>> hw/rtl/lgcp_fifo.sv
// Two-entry job queue between the parser front end and the grid back end.
// Depends on lgcp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lgcp_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lgcp_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output lgcp_pkg::job_t  head_job
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  lgcp_pkg::job_t     slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `LGCP_ASSERT_IMP(a_no_pop_empty, pop, head_valid, "job popped from empty queue")
  `LGCP_ASSERT_IMP(a_no_push_full, push, !full, "job pushed into full queue")

endmodule

>>> hw/rtl/lgcp_back.sv
// Back end: carries out jobs on the LED level store, one row word per cycle,
// and holds the result register. Depends on lgcp_pkg, lgcp_out_if, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lgcp_back #(
  parameter int GRID_ROWS = 10,
  parameter int GRID_COLS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  input  lgcp_pkg::job_t  job_in,
  output logic            pop,
  lgcp_out_if.source      out_ch
);

  localparam int ROW_AW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int WORD_W = lgcp_pkg::WORD_W;
  localparam int LVL_W  = lgcp_pkg::LEVEL_W;
  localparam int CPW    = lgcp_pkg::CELLS_PER_WORD;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_RUN  = 3'b010,
    B_HOLD = 3'b100
  } bstate_t;

  typedef struct packed {
    logic [3:0] level;
    logic [1:0] err;
    logic       done;
    logic       boot;
  } res_t;

  bstate_t              state_r, state_nxt;
  lgcp_pkg::job_t       job_r;
  logic [3:0]           step_r;
  logic [WORD_W-1:0]    led_r [GRID_ROWS];
  res_t                 res_r;
  res_t                 res;
  logic                 out_valid_r;
  res_t                 out_r;
  logic [3:0]           cur_row;
  logic                 last_step;
  logic                 row_ok;
  logic [WORD_W-1:0]    old_word;
  logic [WORD_W-1:0]    new_word;
  logic                 wr_en;
  logic                 out_free;
  logic [WORD_W-1:0]    shifted;

  assign out_free         = !out_valid_r || out_ch.ready;
  assign pop              = (state_r == B_IDLE) && job_valid;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_level   = out_r.level;
  assign out_ch.error_code   = out_r.err;
  assign out_ch.message_done = out_r.done;
  assign out_ch.boot_mode    = out_r.boot;

  // Row word addressed in this step and whether it is the last one.
  always_comb begin
    cur_row   = job_r.row;
    last_step = 1'b1;
    case (job_r.kind)
      lgcp_pkg::K_COLW: begin
        cur_row   = job_r.row + {1'b0, step_r[2:0]};
        last_step = (step_r == 4'd7);
      end
      lgcp_pkg::K_FILL: begin
        cur_row   = step_r;
        last_step = (step_r == 4'(GRID_ROWS - 1));
      end
      default: begin
      end
    endcase
    row_ok   = ({1'b0, cur_row} < 5'(GRID_ROWS));
    old_word = row_ok ? led_r[cur_row[ROW_AW-1:0]] : '0;
  end

  // Read-modify-write of one row word.
  always_comb begin
    logic en;
    logic on;
    new_word = old_word;
    for (int c = 0; c < CPW; c++) begin
      case (job_r.kind)
        lgcp_pkg::K_CELL: begin
          en = (job_r.col == 4'(c));
          on = job_r.bits[0];
        end
        lgcp_pkg::K_ROWW: begin
          en = (job_r.col == 4'd0);
          on = job_r.bits[c];
        end
        lgcp_pkg::K_COLW: begin
          en = (job_r.col == 4'(c));
          on = job_r.bits[step_r[2:0]];
        end
        lgcp_pkg::K_FILL: begin
          en = 1'b1;
          on = job_r.bits[0];
        end
        default: begin
          en = 1'b0;
          on = 1'b0;
        end
      endcase
      if (en && (c < GRID_COLS)) begin
        new_word[c*LVL_W +: LVL_W] = on ? job_r.lvl : '0;
      end
    end
  end

  always_comb begin
    wr_en = (state_r == B_RUN) && row_ok &&
            ((job_r.kind == lgcp_pkg::K_CELL) || (job_r.kind == lgcp_pkg::K_ROWW) ||
             (job_r.kind == lgcp_pkg::K_COLW) || (job_r.kind == lgcp_pkg::K_FILL));
    shifted   = old_word >> {job_r.col[2:0], 2'b00};
    res.level = '0;
    if ((job_r.kind == lgcp_pkg::K_READ) && row_ok && ({1'b0, job_r.col} < 5'(GRID_COLS))) begin
      res.level = shifted[LVL_W-1:0];
    end
    res.err  = job_r.err;
    res.done = job_r.done;
    res.boot = job_r.boot;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          state_nxt = B_RUN;
        end
      end
      B_RUN: begin
        if (last_step) begin
          state_nxt = out_free ? B_IDLE : B_HOLD;
        end
      end
      B_HOLD: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= job_in;
    end
    if ((state_r == B_RUN) && last_step && !out_free) begin
      res_r <= res;
    end
    if ((state_r == B_RUN) && last_step && out_free) begin
      out_r <= res;
    end else if ((state_r == B_HOLD) && out_free) begin
      out_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < GRID_ROWS; r++) begin
        led_r[r] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        step_r <= '0;
      end else if ((state_r == B_RUN) && !last_step) begin
        step_r <= step_r + 4'd1;
      end
      if (wr_en) begin
        led_r[cur_row[ROW_AW-1:0]] <= new_word;
      end
      if (((state_r == B_RUN) && last_step && out_free) ||
          ((state_r == B_HOLD) && out_free)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `LGCP_ASSERT_IMP(a_fill_bound, (state_r == B_RUN) && (job_r.kind == lgcp_pkg::K_FILL), {1'b0, step_r} < 5'(GRID_ROWS), "fill walk ran past last row")

endmodule
